/* sv/mbe_pkg.sv */
// mbe_pkg: control word layout and microprogram for the escape-time iterator
// no dependencies; used by mbe_seq and mandelbrot_escape_iterator
package mbe_pkg;

    localparam int STEP_BITS = 3;

    typedef logic [STEP_BITS-1:0] t_step;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MUL_RR = 2'd0,
        MUL_II = 2'd1,
        MUL_RI = 2'd2
    } t_mul;

    // where the shifted product lands
    typedef enum logic [1:0] {
        CAP_NONE = 2'd0,
        CAP_SR   = 2'd1,
        CAP_SI   = 2'd2,
        CAP_T    = 2'd3
    } t_cap;

    // next-step selection
    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_WAIT_IN  = 2'd1,
        JMP_LOOP     = 2'd2,
        JMP_WAIT_OUT = 2'd3
    } t_jmp;

    typedef struct packed {
        t_mul  mul;
        t_cap  cap;
        logic  load;
        logic  esc;
        logic  upd;
        logic  emit;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    // conditions the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic done;
        logic out_free;
    } t_cond;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_LOOP  = 3'd1;

    function automatic t_uword urom(input t_step addr);
        t_uword w;
        w = '{mul: MUL_RR, cap: CAP_NONE, load: 1'b0, esc: 1'b0, upd: 1'b0,
              emit: 1'b0, jmp: JMP_NEXT, target: STEP_IDLE};
        unique case (addr)
            3'd0: begin
                w.load = 1'b1;
                w.jmp  = JMP_WAIT_IN;
            end
            3'd1: begin
                w.mul = MUL_RR;
            end
            3'd2: begin
                w.mul = MUL_II;
                w.cap = CAP_SR;
            end
            3'd3: begin
                w.mul = MUL_RI;
                w.cap = CAP_SI;
            end
            3'd4: begin
                w.cap = CAP_T;
                w.esc = 1'b1;
            end
            3'd5: begin
                w.upd    = 1'b1;
                w.jmp    = JMP_LOOP;
                w.target = STEP_LOOP;
            end
            3'd6: begin
                w.emit   = 1'b1;
                w.jmp    = JMP_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            default: begin
                w.jmp    = JMP_WAIT_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/mbe_seq.sv */
// mbe_seq: step counter, microprogram read and conditional branching
// depends on mbe_pkg
module mbe_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbe_pkg::t_cond  i_cond,
    output mbe_pkg::t_uword o_ctrl
);
    import mbe_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;

    assign w_word = urom(r_step);
    assign o_ctrl = w_word;

    always_comb begin
        n_step = r_step;
        unique case (w_word.jmp)
            JMP_NEXT:     n_step = r_step + 1'b1;
            JMP_WAIT_IN:  if (i_cond.in_valid) n_step = r_step + 1'b1;
            JMP_LOOP:     n_step = i_cond.done ? r_step + 1'b1 : w_word.target;
            JMP_WAIT_OUT: if (i_cond.out_free) n_step = w_word.target;
            default:      n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* sv/mandelbrot_escape_iterator.sv */
// mandelbrot_escape_iterator: escape-time iteration z = z*z + c in signed fixed point
// depends on mbe_pkg and mbe_seq
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, budget, z0, c    | into block
//  out     | o_out_valid / i_out_ready, count, final z | out of block
//
// one shared 32x32 multiplier; an iteration steps through three products, the escape
// test and the z update; a job holds the sequencer through the idle step, N iterations
// and the emit step, N being the iterations actually run
// the finished beat sits in an output register; the next job starts while it waits
// the emit step stalls only while the previous result beat is still unaccepted
// reset is synchronous, active low; clears the step counter and output valid
module mandelbrot_escape_iterator #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [15:0] i_iteration_budget,
    input  logic signed [31:0] i_start_real,
    input  logic signed [31:0] i_start_imag,
    input  logic signed [31:0] i_point_real,
    input  logic signed [31:0] i_point_imag,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [15:0] o_escape_count,
    output logic signed [31:0] o_final_real,
    output logic signed [31:0] o_final_imag
);
    import mbe_pkg::*;

    localparam int SW = 64 - FRAC_BITS;   // width of a shifted product
    localparam int EW = SW + 2;           // width of an updated z before saturation
    localparam logic signed [SW:0] LIMIT = (SW+1)'(64'd4 << FRAC_BITS);

    t_uword w_ctrl;
    t_cond  w_cond;

    logic signed [31:0]       r_zr, r_zi, r_cr, r_ci;
    logic [COUNT_BITS-1:0]    r_left;
    logic signed [63:0]       r_prod;
    logic signed [SW-1:0]     r_sr, r_si, r_t;
    logic                     r_esc;
    logic                     r_out_valid;
    logic [15:0]              r_count;
    logic signed [31:0]       r_fr, r_fi;

    logic signed [31:0]       w_ma, w_mb;
    logic signed [SW-1:0]     w_shift;
    logic signed [SW:0]       w_mag;
    logic signed [EW-1:0]     w_nr, w_ni;
    logic [COUNT_BITS-1:0]    w_load_left;
    logic                     w_accept;
    logic                     w_out_free;

    function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] x);
        logic [EW-32:0] hi;
        hi = x[EW-1:31];
        if (hi == '0 || hi == '1) begin
            return x[31:0];
        end else if (x[EW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    mbe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_ready = w_ctrl.load;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_cond.in_valid = i_in_valid;
    assign w_cond.done     = r_esc || (r_left == COUNT_BITS'(1));
    assign w_cond.out_free = w_out_free;

    always_comb begin
        unique case (w_ctrl.mul)
            MUL_RR: begin
                w_ma = r_zr;
                w_mb = r_zr;
            end
            MUL_II: begin
                w_ma = r_zi;
                w_mb = r_zi;
            end
            MUL_RI: begin
                w_ma = r_zr;
                w_mb = r_zi;
            end
            default: begin
                w_ma = r_zr;
                w_mb = r_zr;
            end
        endcase
    end

    // arithmetic shift is the floor of the scaled product
    assign w_shift = SW'(r_prod >>> FRAC_BITS);
    assign w_mag   = (SW+1)'(r_sr) + (SW+1)'(r_si);
    assign w_nr    = EW'(r_sr) - EW'(r_si) + EW'(r_cr);
    assign w_ni    = EW'(r_t) + EW'(r_t) + EW'(r_ci);

    // a zero budget runs one iteration
    assign w_load_left = (COUNT_BITS'(i_iteration_budget) == '0) ? COUNT_BITS'(1)
                                                               : COUNT_BITS'(i_iteration_budget);

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_accept) begin
            r_zr   <= i_start_real;
            r_zi   <= i_start_imag;
            r_cr   <= i_point_real;
            r_ci   <= i_point_imag;
            r_left <= w_load_left;
        end
        unique case (w_ctrl.cap)
            CAP_NONE: ;
            CAP_SR:   r_sr <= w_shift;
            CAP_SI:   r_si <= w_shift;
            CAP_T:    r_t  <= w_shift;
            default:  ;
        endcase
        if (w_ctrl.esc) begin
            r_esc <= w_mag > LIMIT;
        end
        if (w_ctrl.upd) begin
            r_zr   <= sat32(w_nr);
            r_zi   <= sat32(w_ni);
            r_left <= r_left - 1'b1;
        end
        if (w_ctrl.emit && w_out_free) begin
            r_count <= r_esc ? 16'(r_left) : 16'd0;
            r_fr    <= r_zr;
            r_fi    <= r_zi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_count;
    assign o_final_real   = r_fr;
    assign o_final_imag   = r_fi;

    // a result beat only appears right after the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.emit))
        else $error("output valid rose without an emit step");

    // the iteration counter never wraps through zero
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.upd |-> r_left != '0)
        else $error("iteration update with an exhausted budget");

    // the input side is only open in the idle step
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("accepted a second job without iterating");

endmodule

/* dv/mandelbrot_escape_checker.sv */
`timescale 1ns / 1ps
// mandelbrot_escape_checker: watches the job and result channels of the iterator,
// predicts each result from its job beat and compares them in order; no dependencies
module mandelbrot_escape_checker #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic        [15:0] i_iteration_budget,
    input  logic signed [31:0] i_start_real,
    input  logic signed [31:0] i_start_imag,
    input  logic signed [31:0] i_point_real,
    input  logic signed [31:0] i_point_imag,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic        [15:0] i_escape_count,
    input  logic signed [31:0] i_final_real,
    input  logic signed [31:0] i_final_imag,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint Z_MAX     = 64'sd2147483647;
    localparam longint Z_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic        [15:0] count;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_pixel;

    t_pixel pixel_q[$];
    int     fails = 0;

    assign o_fail_count = fails;

    function automatic longint clamp_q8(input longint v);
        if (v > Z_MAX) return Z_MAX;
        if (v < Z_MIN) return Z_MIN;
        return v;
    endfunction

    function automatic t_pixel escape_time(input logic [15:0] budget,
                                           input logic signed [31:0] z_re,
                                           input logic signed [31:0] z_im,
                                           input logic signed [31:0] c_re,
                                           input logic signed [31:0] c_im);
        longint zr, zi, sr, si, t;
        int     left;
        int     remain;
        logic   esc;
        t_pixel px;
        left   = int'(budget) & ((1 << COUNT_BITS) - 1);
        remain = 0;
        zr     = z_re;
        zi     = z_im;
        if (left == 0) left = 1;
        do begin
            // arithmetic shift of the exact product is a floor
            sr  = (zr * zr) >>> FRAC_BITS;
            si  = (zi * zi) >>> FRAC_BITS;
            t   = (zr * zi) >>> FRAC_BITS;
            esc = (sr + si) > (longint'(4) <<< FRAC_BITS);
            zr  = clamp_q8(sr - si + c_re);
            zi  = clamp_q8(t + t + c_im);
            left--;
            if (esc) begin
                remain = left;
                left   = 0;
            end
        end while (left != 0);
        px.count = 16'(remain & ((1 << COUNT_BITS) - 1));
        px.re    = zr[31:0];
        px.im    = zi[31:0];
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            // pop before push: a job beat cannot be answered in its own cycle
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("result beat with no job outstanding, count", 0,
                                    i_escape_count);
                end else begin
                    want = pixel_q.pop_front();
                    if (i_escape_count !== want.count)
                        report_mismatch("escape_count", want.count, i_escape_count);
                    if (i_final_real !== want.re)
                        report_mismatch("final_real", want.re, i_final_real);
                    if (i_final_imag !== want.im)
                        report_mismatch("final_imag", want.im, i_final_imag);
                end
            end
            if (i_in_valid && i_in_ready)
                pixel_q.push_back(escape_time(i_iteration_budget, i_start_real,
                                              i_start_imag, i_point_real, i_point_imag));
        end
        o_pending <= pixel_q.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives pixel jobs into mandelbrot_escape_iterator and stalls its results
// depends on mandelbrot_escape_iterator and mandelbrot_escape_checker
module testbench;

    localparam int RANDOM_JOBS  = 1735;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 64;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_in_valid         = 1'b0;
    logic        [15:0] i_iteration_budget = '0;
    logic signed [31:0] i_start_real       = '0;
    logic signed [31:0] i_start_imag       = '0;
    logic signed [31:0] i_point_real       = '0;
    logic signed [31:0] i_point_imag       = '0;
    logic               i_out_ready        = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic        [15:0] o_escape_count;
    logic signed [31:0] o_final_real;
    logic signed [31:0] o_final_imag;

    logic calm = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    mandelbrot_escape_iterator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_iteration_budget (i_iteration_budget),
        .i_start_real       (i_start_real),
        .i_start_imag       (i_start_imag),
        .i_point_real       (i_point_real),
        .i_point_imag       (i_point_imag),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_escape_count     (o_escape_count),
        .o_final_real       (o_final_real),
        .o_final_imag       (o_final_imag)
    );

    mandelbrot_escape_checker u_scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_iteration_budget (i_iteration_budget),
        .i_start_real       (i_start_real),
        .i_start_imag       (i_start_imag),
        .i_point_real       (i_point_real),
        .i_point_imag       (i_point_imag),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_escape_count     (o_escape_count),
        .i_final_real       (o_final_real),
        .i_final_imag       (o_final_imag),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // any beat on either channel counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_job(input logic [15:0] budget,
                            input logic signed [31:0] z_re, input logic signed [31:0] z_im,
                            input logic signed [31:0] c_re, input logic signed [31:0] c_im);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_iteration_budget <= budget;
        i_start_real       <= z_re;
        i_start_imag       <= z_im;
        i_point_real       <= c_re;
        i_point_imag       <= c_im;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic        [15:0] n;
        logic signed [31:0] zr, zi, cr, ci;
        logic        [31:0] m;
        int                 mix;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero budget runs one iteration
        send_job(16'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        // escape on the last iteration gives the same count as no escape
        send_job(16'd1, 32'sh0300_0000, 32'sh0, 32'sh0, 32'sh0);
        send_job(16'hFFFF, 32'sh0300_0000, 32'sh0, 32'sh0, 32'sh0);
        send_job(16'hFFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_job(16'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_job(16'd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_job(16'd3, 32'sh0, 32'sh7FFF_FFFF, 32'sh0, 32'sh0);
        send_job(16'h8000, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0);
        send_job(16'd20, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        // c = -1 settles into an orbit of period two
        send_job(16'd100, 32'sh0, 32'sh0, 32'shFF00_0000, 32'sh0);
        // c = -2 keeps |z|^2 at exactly 4, never strictly above
        send_job(16'd40, 32'sh0, 32'sh0, 32'shFE00_0000, 32'sh0);
        send_job(16'd8, 32'sh0200_0000, 32'sh0, 32'sh0, 32'sh0);
        send_job(16'd8, 32'sh0200_0001, 32'sh0, 32'sh0, 32'sh0);
        send_job(16'd12, 32'sh0, 32'sh0200_0000, 32'sh0, 32'sh0200_0000);
        // tiny negative cross product floors to -1
        send_job(16'd3, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0, 32'sh0);
        // c just outside the cusp escapes slowly
        send_job(16'd60, 32'sh0, 32'sh0, 32'sh0042_8F5C, 32'sh0);
        send_job(16'd1024, 32'sh0, 32'sh0, 32'shFF80_0000, 32'sh0080_0000);
        drain_results();

        for (int k = 0; k < RANDOM_JOBS; k++) begin
            calm <= (k >= 600 && k < 900);
            if (k == 1000) drain_results();
            mix = $urandom_range(0, 99);
            if (mix < 70) begin
                // points around the set, mostly short budgets
                n  = ($urandom_range(0, 99) < 3) ? 16'($urandom_range(129, 1024))
                                                 : 16'($urandom_range(1, 128));
                cr = $urandom_range(0, 32'h0300_0000) - 32'h0240_0000;
                ci = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
                if ($urandom_range(0, 99) < 60) begin
                    zr = '0;
                    zi = '0;
                end else begin
                    zr = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                    zi = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                end
            end else if (mix < 90) begin
                // any budget, but |z0| >= 3 escapes on the first iteration
                n  = 16'($urandom_range(0, 16'hFFFF));
                m  = $urandom_range(32'h0300_0000, 32'h7FFF_FFFF);
                cr = $urandom;
                ci = $urandom;
                if ($urandom_range(0, 1)) begin
                    zr = $urandom_range(0, 1) ? -m : m;
                    zi = $urandom;
                end else begin
                    zi = $urandom_range(0, 1) ? -m : m;
                    zr = $urandom;
                end
            end else begin
                n  = 16'($urandom_range(0, 64));
                zr = $urandom;
                zi = $urandom;
                cr = $urandom;
                ci = $urandom;
            end
            send_job(n, zr, zi, cr, ci);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
